>>> hdl/q16_pkg.sv
package q16_pkg;

  typedef enum logic [1:0] {
    MODE_MUL = 2'd0,
    MODE_DIV = 2'd1,
    MODE_CVT = 2'd2,
    MODE_ABS = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_DIV0   = 2'd1,
    ERR_NANINF = 2'd2
  } err_e;

  localparam logic [7:0]  FLT_EXP_MAX   = 8'hff;
  localparam int unsigned FLT_BIAS_BASE = 150;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

endpackage

>>> hdl/q16_div_stage.sv
// STEP_N restoring division steps: brings in numerator bits, subtracts the divisor if it fits.
module q16_div_stage #(
  parameter int unsigned NUM_W  = 48,
  parameter int unsigned STEP_N = 4
) (
  input  logic [NUM_W-1:0] num_i,
  input  logic [32:0]      rem_i,
  input  logic [NUM_W-1:0] quo_i,
  input  logic [31:0]      den_i,
  output logic [NUM_W-1:0] num_o,
  output logic [32:0]      rem_o,
  output logic [NUM_W-1:0] quo_o
);
  always_comb begin
    logic [32:0]      r;
    logic [NUM_W-1:0] n;
    logic [NUM_W-1:0] q;
    logic [33:0]      t;
    r = rem_i;
    n = num_i;
    q = quo_i;
    for (int k = 0; k < STEP_N; k++) begin
      t = {r, n[NUM_W-1]};
      n = {n[NUM_W-2:0], 1'b0};
      if (t >= {2'b00, den_i}) begin
        t = t - {2'b00, den_i};
        q = {q[NUM_W-2:0], 1'b1};
      end else begin
        q = {q[NUM_W-2:0], 1'b0};
      end
      r = t[32:0];
    end
    num_o = n;
    rem_o = r;
    quo_o = q;
  end
endmodule

>>> hdl/q16_cvt.sv
// Float32 bit pattern to fixed point, with NaN/Inf flag.
module q16_cvt #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic [31:0] flt_i,
  output logic [31:0] val_o,
  output logic        nan_o
);
  import q16_pkg::*;

  localparam int signed SHIFT_BIAS = FLT_BIAS_BASE - FRAC_BITS;

  logic [7:0]  ex;
  logic [23:0] mant;
  logic signed [9:0] sh;
  logic [31:0] mag;

  assign ex   = flt_i[30:23];
  assign mant = {1'b1, flt_i[22:0]};
  assign sh   = $signed({2'b00, ex}) - 10'(SHIFT_BIAS);

  always_comb begin
    mag = '0;
    if (sh >= 0) begin
      if (sh < 32) mag = {8'd0, mant} << sh[4:0];
    end else if (sh > -32) begin
      mag = {8'd0, mant} >> 5'(-sh);
    end
  end

  assign nan_o = (ex == FLT_EXP_MAX);
  assign val_o = (nan_o || ex == '0) ? '0 : (flt_i[31] ? 32'd0 - mag : mag);
endmodule

>>> hdl/q16_fixed_point_alu.sv
// Signed fixed-point arithmetic unit (Q16.16 by default). One operation per
// transaction, one result per operation, in order. Fully pipelined: a new
// transaction enters every cycle unless the output stalls. An operation passes
// the stage 0, stage 1, DSTG divider and output registers, where DSTG =
// ceil((32 + FRAC_BITS) / 4) is the number of restoring divider stages of 4
// quotient bits each (numerator padded up to a multiple of 4 bits). The multiply
// goes through four 16x16 partial products in one stage, summed in the next;
// convert and abs ride along. Modes: multiply (truncate toward zero), divide
// (floor of magnitudes, sign restored; zero divisor flags error 1 and returns 0),
// float32 convert (NaN/Inf flags error 2), abs. A stall holds the whole pipe.
module q16_fixed_point_alu #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata: operand_a[31:0], operand_b[63:32]
  input  logic [63:0]         s_axis_tdata_i,
  // tuser: mode[1:0]
  input  q16_pkg::mode_e      s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // tdata: result[31:0]
  output logic [31:0]         m_axis_tdata_o,
  // tuser: error[1:0]
  output q16_pkg::err_e       m_axis_tuser_o
);
  import q16_pkg::*;

  localparam int unsigned STEP_N = 4;
  localparam int unsigned DSTG   = (32 + FRAC_BITS + STEP_N - 1) / STEP_N;
  localparam int unsigned NUM_W  = DSTG * STEP_N;
  localparam int unsigned NS     = DSTG + 2;

  typedef struct packed {
    mode_e       mode;
    logic        neg;
    logic [31:0] aux;   // abs / convert result, or the summed product
    err_e        err;
  } ctl_t;

  // advance whole pipe when the output register is free or being taken
  logic adv;
  logic [NS-1:0] vld_q;
  assign adv = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  logic [31:0] a_in, b_in, ma, mb;
  assign a_in = s_axis_tdata_i[31:0];
  assign b_in = s_axis_tdata_i[63:32];
  assign ma = mag32(a_in);
  assign mb = mag32(b_in);

  logic [31:0] cvt_val;
  logic        cvt_nan;
  q16_cvt #(.FRAC_BITS(FRAC_BITS)) u_cvt (.flt_i(a_in), .val_o(cvt_val), .nan_o(cvt_nan));

  // stage 0: magnitudes, partial products, convert/abs
  ctl_t        c0_d;
  ctl_t        c0_q;
  logic [31:0] pp_q [4];
  logic [NUM_W-1:0] n0_q;
  logic [31:0] d0_q;
  always_comb begin
    c0_d.mode = s_axis_tuser_i;
    c0_d.neg  = a_in[31] ^ b_in[31];
    c0_d.err  = ERR_OK;
    c0_d.aux  = ma;
    unique case (s_axis_tuser_i)
      MODE_DIV: if (mb == '0) c0_d.err = ERR_DIV0;
      MODE_CVT: begin
        c0_d.aux = cvt_val;
        if (cvt_nan) c0_d.err = ERR_NANINF;
      end
      default: ;
    endcase
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c0_q <= c0_d;
      pp_q[0] <= ma[15:0]  * mb[15:0];
      pp_q[1] <= ma[31:16] * mb[15:0];
      pp_q[2] <= ma[15:0]  * mb[31:16];
      pp_q[3] <= ma[31:16] * mb[31:16];
      n0_q <= NUM_W'({ma, FRAC_BITS'(0)});
      d0_q <= mb;
    end
  end

  // stage 1: product sum; divider starts
  ctl_t        c1_d;
  ctl_t        c1_q [DSTG+1];
  logic [NUM_W-1:0] n_q [DSTG+1];
  logic [NUM_W-1:0] q_q [DSTG+1];
  logic [32:0]      r_q [DSTG+1];
  logic [31:0]      d_q [DSTG+1];
  logic [63:0]      prod;
  assign prod = {32'd0, pp_q[0]} + {16'd0, pp_q[1], 16'd0} + {16'd0, pp_q[2], 16'd0}
              + {pp_q[3], 32'd0};
  always_comb begin
    c1_d = c0_q;
    if (c0_q.mode == MODE_MUL) c1_d.aux = prod[FRAC_BITS +: 32];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q[0] <= c1_d;
      n_q[0] <= n0_q;
      q_q[0] <= '0;
      r_q[0] <= '0;
      d_q[0] <= d0_q;
    end
  end

  // divider stages
  for (genvar g = 0; g < DSTG; g++) begin : g_div
    logic [NUM_W-1:0] nn, qq;
    logic [32:0] rr;
    q16_div_stage #(.NUM_W(NUM_W), .STEP_N(STEP_N)) u_stg (
      .num_i(n_q[g]), .rem_i(r_q[g]), .quo_i(q_q[g]), .den_i(d_q[g]),
      .num_o(nn), .rem_o(rr), .quo_o(qq));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        c1_q[g+1] <= c1_q[g];
        n_q[g+1]  <= nn;
        r_q[g+1]  <= rr;
        q_q[g+1]  <= qq;
        d_q[g+1]  <= d_q[g];
      end
    end
  end

  // tail: pick result, restore sign
  logic [31:0] mag_f, res_f;
  ctl_t        ct;
  assign ct = c1_q[DSTG];
  always_comb begin
    mag_f = ct.aux;
    if (ct.mode == MODE_DIV) mag_f = q_q[DSTG][31:0];
    res_f = mag_f;
    if ((ct.mode == MODE_MUL || ct.mode == MODE_DIV) && ct.neg) res_f = 32'd0 - mag_f;
    if (ct.err != ERR_OK) res_f = '0;
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], s_axis_tvalid_i};
    end
  end

  // output register
  logic        ov_q;
  logic [31:0] od_q;
  err_e        oe_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= vld_q[NS-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      od_q <= res_f;
      oe_q <= ct.err;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;
  assign m_axis_tuser_o  = oe_q;
endmodule

>>> tb/sv/q16_alu_checker.sv
module q16_alu_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  input  logic               s_ready_i,
  input  logic [63:0]        s_data_i,
  input  q16_pkg::mode_e     s_user_i,
  input  logic               m_valid_i,
  input  logic               m_ready_i,
  input  logic [31:0]        m_data_i,
  input  q16_pkg::err_e      m_user_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        ops_seen_o
);
  import q16_pkg::*;

  localparam int unsigned FRAC = 16;

  typedef struct packed {
    logic [31:0] value;
    err_e        err;
  } alu_out_t;

  alu_out_t expected_q[$];
  int unsigned mismatches;
  int unsigned ops_seen;

  function automatic logic [31:0] magnitude(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] float_to_q(input logic [31:0] f, output err_e err);
    logic [7:0]  ex;
    logic [31:0] mant;
    logic [31:0] val;
    int          sh;
    ex   = f[30:23];
    mant = {8'd0, 1'b1, f[22:0]};
    err  = ERR_OK;
    if (ex == FLT_EXP_MAX) begin
      err = ERR_NANINF;
      return 32'd0;
    end
    if (ex == 8'd0) return 32'd0;
    sh = int'(ex) - (int'(FLT_BIAS_BASE) - int'(FRAC));
    if (sh >= 0) val = (sh >= 32) ? 32'd0 : (mant << sh);
    else val = (-sh >= 32) ? 32'd0 : (mant >> (-sh));
    return f[31] ? (32'd0 - val) : val;
  endfunction

  function automatic alu_out_t compute_alu(input mode_e md, input logic [31:0] a,
                                           input logic [31:0] b);
    alu_out_t    r;
    logic        neg;
    logic [63:0] wide;
    neg   = a[31] ^ b[31];
    r.err = ERR_OK;
    unique case (md)
      MODE_MUL: begin
        wide    = {32'd0, magnitude(a)} * {32'd0, magnitude(b)};
        r.value = wide[FRAC +: 32];
        if (neg) r.value = 32'd0 - r.value;
      end
      MODE_DIV: begin
        if (magnitude(b) == 32'd0) begin
          r.err   = ERR_DIV0;
          r.value = 32'd0;
        end else begin
          wide    = ({32'd0, magnitude(a)} << FRAC) / {32'd0, magnitude(b)};
          r.value = wide[31:0];
          if (neg) r.value = 32'd0 - r.value;
        end
      end
      MODE_CVT: r.value = float_to_q(a, r.err);
      default:  r.value = magnitude(a);
    endcase
    return r;
  endfunction

  always @(posedge clk_i) begin
    alu_out_t exp_r;
    if (rst_ni) begin
      // predict on input transaction
      if (s_valid_i && s_ready_i) begin
        expected_q.push_back(compute_alu(s_user_i, s_data_i[31:0], s_data_i[63:32]));
        ops_seen++;
      end
      // compare on output transaction
      if (m_valid_i && m_ready_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h err %0d", m_data_i, m_user_i);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.value !== m_data_i || exp_r.err !== m_user_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h err %0d, got %h err %0d",
                       exp_r.value, exp_r.err, m_data_i, m_user_i);
          end
        end
      end
    end
  end

  assign fail_count_o = mismatches;
  assign pending_o    = expected_q.size();
  assign ops_seen_o   = ops_seen;
endmodule

>>> tb/sv/tb_q16_fixed_point_alu.sv
module tb_q16_fixed_point_alu;
  import q16_pkg::*;

  localparam int unsigned RANDOM_OPS = 1330;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 30;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_data;
  mode_e       in_mode;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_data;
  err_e        out_err;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned ops_seen;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;
  bit          timed_out;

  q16_fixed_point_alu uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_mode),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data),
    .m_axis_tuser_o  (out_err)
  );

  q16_alu_checker checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_valid_i    (in_valid),
    .s_ready_i    (in_ready),
    .s_data_i     (in_data),
    .s_user_i     (in_mode),
    .m_valid_i    (out_valid),
    .m_ready_i    (out_ready),
    .m_data_i     (out_data),
    .m_user_i     (out_err),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .ops_seen_o   (ops_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Toggle ready at random per the current receiver idle rate.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Count cycles with no transaction on either side; bail out on a hang.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Present one operation, inserting random sender idles, and hold until taken.
  task automatic send_op(input mode_e md, input logic [31:0] a, input logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= md;
    in_data  <= {b, a};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Build a float whose exponent lands around the interesting shift window.
  function automatic logic [31:0] rand_float();
    logic [7:0] ex;
    case ($urandom_range(5))
      0:       ex = 8'hff;
      1:       ex = 8'h00;
      2:       ex = 8'($urandom_range(166, 100));
      default: ex = 8'($urandom_range(148, 118));
    endcase
    return {1'($urandom_range(1)), ex, 23'($urandom)};
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'($urandom_range(3)) - 32'd1;
      2:       return {{16{1'($urandom_range(1))}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(input int unsigned count);
    mode_e       md;
    logic [31:0] a;
    logic [31:0] b;
    for (int unsigned i = 0; i < count; i++) begin
      md = mode_e'($urandom_range(3));
      a  = (md == MODE_CVT) ? rand_float() : rand_word();
      b  = ($urandom_range(15) == 0) ? 32'd0 : rand_word();
      send_op(md, a, b);
    end
  endtask

  initial begin
    send_idle_pct = 27;
    recv_idle_pct = 54;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    in_mode       = MODE_MUL;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of each mode and the named corner cases.
    send_op(MODE_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    send_op(MODE_MUL, 32'h8000_0000, 32'h8000_0000);
    send_op(MODE_MUL, 32'h8000_0000, 32'h0001_0000);
    send_op(MODE_MUL, 32'hffff_ffff, 32'h0000_0001);
    send_op(MODE_MUL, 32'h0003_8000, 32'hfffe_0000);
    send_op(MODE_DIV, 32'h0001_0000, 32'h0000_0000);
    send_op(MODE_DIV, 32'h8000_0000, 32'h0000_0001);
    send_op(MODE_DIV, 32'h7fff_ffff, 32'h8000_0000);
    send_op(MODE_DIV, 32'hfffd_0000, 32'h0002_0000);
    send_op(MODE_DIV, 32'h0000_0000, 32'hffff_ffff);
    send_op(MODE_CVT, 32'h7f80_0000, 32'h1234_5678);
    send_op(MODE_CVT, 32'hffc0_0001, 32'h0);
    send_op(MODE_CVT, 32'h0000_0001, 32'h0);
    send_op(MODE_CVT, 32'h8000_0000, 32'h0);
    send_op(MODE_CVT, 32'h3fc0_0000, 32'h0);
    send_op(MODE_CVT, 32'hc2f6_e979, 32'h0);
    send_op(MODE_CVT, 32'h4f00_0000, 32'h0);
    send_op(MODE_CVT, 32'h4700_0000, 32'h0);
    send_op(MODE_CVT, 32'h3380_0000, 32'h0);
    send_op(MODE_CVT, 32'h0080_0000, 32'h0);
    send_op(MODE_ABS, 32'h8000_0000, 32'hffff_ffff);
    send_op(MODE_ABS, 32'hffff_ffff, 32'h0);
    send_op(MODE_ABS, 32'h7fff_ffff, 32'h0);
    send_op(MODE_ABS, 32'h0000_0000, 32'h8000_0000);

    // Random: swap idle rates between phases, then run at full rate.
    run_random(RANDOM_OPS / 3);
    send_idle_pct = 54;
    recv_idle_pct = 27;
    run_random(RANDOM_OPS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_OPS - 2 * (RANDOM_OPS / 3));
    in_valid <= 1'b0;

    // Drain: wait for every expected result, then a short settle window.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d operations across all four modes with sender/receiver stalls,",
             ops_seen);
    $display("including divide by zero, NaN/Inf, subnormal and most-negative operands.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
